FILE: rtl/core/diff_drive_odometry_defines.svh
// Assertion macros for the odometry block
`ifndef DIFF_DRIVE_ODOMETRY_DEFINES_SVH
`define DIFF_DRIVE_ODOMETRY_DEFINES_SVH
`ifndef SYNTHESIS
`define DDO_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define DDO_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define DDO_ASSERT_IMPL(label, clk, rst, ante, cons)
`define DDO_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

FILE: rtl/core/ddo_pkg.sv
package ddo_pkg;
   localparam int TrigFracBits = 15;
   localparam int CordicSteps = 30;
   localparam int StepBits = 5;
   localparam logic [31:0] CordicGainQ30 = 32'd652032874;
   localparam logic [31:0] TurnGainReset = 32'd55997;
   localparam logic [31:0] RateGainReset = 32'd40960;

   localparam logic CSR_TURN_GAIN = 1'b0;
   localparam logic CSR_RATE_GAIN = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE, ST_CORDIC, ST_TRIG, ST_MUL_SC, ST_MUL_SS, ST_MUL_XT, ST_MUL_YT,
      ST_MUL_MT, ST_MUL_DG, ST_MUL_RG, ST_UPDATE, ST_OUT
   } state_type;

   typedef enum logic [3:0] {
      OP_NONE, OP_LOAD, OP_CORDIC, OP_TRIG, OP_MUL_SC, OP_MUL_SS, OP_MUL_XT,
      OP_MUL_YT, OP_MUL_MT, OP_MUL_DG, OP_MUL_RG, OP_UPDATE
   } op_type;

   typedef struct packed {
      op_type op;
      logic [StepBits-1:0] step;
   } cmd_type;

   function automatic logic [31:0] atan_lut(input logic [StepBits-1:0] i);
      logic [31:0] a;
      case (i)
         5'd0: a = 32'd536870912;  5'd1: a = 32'd316933406;
         5'd2: a = 32'd167458907;  5'd3: a = 32'd85004756;
         5'd4: a = 32'd42667331;   5'd5: a = 32'd21354465;
         5'd6: a = 32'd10679838;   5'd7: a = 32'd5340245;
         5'd8: a = 32'd2670163;    5'd9: a = 32'd1335087;
         5'd10: a = 32'd667544;    5'd11: a = 32'd333772;
         5'd12: a = 32'd166886;    5'd13: a = 32'd83443;
         5'd14: a = 32'd41722;     5'd15: a = 32'd20861;
         5'd16: a = 32'd10430;     5'd17: a = 32'd5215;
         5'd18: a = 32'd2608;      5'd19: a = 32'd1304;
         5'd20: a = 32'd652;       5'd21: a = 32'd326;
         5'd22: a = 32'd163;       5'd23: a = 32'd81;
         5'd24: a = 32'd41;        5'd25: a = 32'd20;
         5'd26: a = 32'd10;        5'd27: a = 32'd5;
         5'd28: a = 32'd3;         5'd29: a = 32'd1;
         default: a = 32'd0;
      endcase
      return a;
   endfunction
endpackage

FILE: rtl/core/ddo_if.sv
interface ddo_req_if;
   logic valid;
   logic ready;
   logic signed [15:0] left_speed;
   logic signed [15:0] right_speed;
   logic [15:0] elapsed_time;
   modport source (output valid, left_speed, right_speed, elapsed_time, input ready);
   modport sink (input valid, left_speed, right_speed, elapsed_time, output ready);
endinterface

interface ddo_rsp_if;
   logic valid;
   logic ready;
   logic signed [47:0] pos_x;
   logic signed [47:0] pos_y;
   logic [31:0] heading;
   logic signed [15:0] world_vel_x;
   logic signed [31:0] turn_rate;
   modport source (output valid, pos_x, pos_y, heading, world_vel_x, turn_rate, input ready);
   modport sink (input valid, pos_x, pos_y, heading, world_vel_x, turn_rate, output ready);
endinterface

interface ddo_csr_if;
   logic valid;
   logic ready;
   logic index;
   logic [31:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/core/ddo_ctrl.sv
module ddo_ctrl (
   input  logic clock,
   input  logic reset,
   input  logic req_fire,
   input  logic rsp_fire,
   output logic busy,
   output logic rsp_valid,
   output ddo_pkg::cmd_type cmd
);
   ddo_pkg::state_type state_ff, state_in;
   logic [ddo_pkg::StepBits-1:0] step_ff, step_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ddo_pkg::ST_IDLE;
         step_ff <= '0;
      end else begin
         state_ff <= state_in;
         step_ff <= step_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      step_in = step_ff;
      cmd.op = ddo_pkg::OP_NONE;
      cmd.step = step_ff;
      busy = 1'b1;
      rsp_valid = 1'b0;
      case (state_ff)
         ddo_pkg::ST_IDLE: begin
            busy = 1'b0;
            if (req_fire) begin
               cmd.op = ddo_pkg::OP_LOAD;
               step_in = '0;
               state_in = ddo_pkg::ST_CORDIC;
            end
         end
         ddo_pkg::ST_CORDIC: begin
            cmd.op = ddo_pkg::OP_CORDIC;
            step_in = step_ff + 1'b1;
            if (step_ff == ddo_pkg::StepBits'(ddo_pkg::CordicSteps - 1))
               state_in = ddo_pkg::ST_TRIG;
         end
         ddo_pkg::ST_TRIG: begin
            cmd.op = ddo_pkg::OP_TRIG; state_in = ddo_pkg::ST_MUL_SC;
         end
         ddo_pkg::ST_MUL_SC: begin
            cmd.op = ddo_pkg::OP_MUL_SC; state_in = ddo_pkg::ST_MUL_SS;
         end
         ddo_pkg::ST_MUL_SS: begin
            cmd.op = ddo_pkg::OP_MUL_SS; state_in = ddo_pkg::ST_MUL_XT;
         end
         ddo_pkg::ST_MUL_XT: begin
            cmd.op = ddo_pkg::OP_MUL_XT; state_in = ddo_pkg::ST_MUL_YT;
         end
         ddo_pkg::ST_MUL_YT: begin
            cmd.op = ddo_pkg::OP_MUL_YT; state_in = ddo_pkg::ST_MUL_MT;
         end
         ddo_pkg::ST_MUL_MT: begin
            cmd.op = ddo_pkg::OP_MUL_MT; state_in = ddo_pkg::ST_MUL_DG;
         end
         ddo_pkg::ST_MUL_DG: begin
            cmd.op = ddo_pkg::OP_MUL_DG; state_in = ddo_pkg::ST_MUL_RG;
         end
         ddo_pkg::ST_MUL_RG: begin
            cmd.op = ddo_pkg::OP_MUL_RG; state_in = ddo_pkg::ST_UPDATE;
         end
         ddo_pkg::ST_UPDATE: begin
            cmd.op = ddo_pkg::OP_UPDATE; state_in = ddo_pkg::ST_OUT;
         end
         ddo_pkg::ST_OUT: begin
            rsp_valid = 1'b1;
            if (rsp_fire) state_in = ddo_pkg::ST_IDLE;
         end
         default: state_in = ddo_pkg::ST_IDLE;
      endcase
   end
endmodule

FILE: rtl/core/ddo_dp.sv
module ddo_dp (
   input  logic clock,
   input  logic reset,
   input  ddo_pkg::cmd_type cmd,
   input  logic signed [15:0] left_speed,
   input  logic signed [15:0] right_speed,
   input  logic [15:0] elapsed_time,
   input  logic csr_we,
   input  logic csr_index,
   input  logic [31:0] csr_data,
   output logic signed [47:0] pos_x,
   output logic signed [47:0] pos_y,
   output logic [31:0] heading,
   output logic signed [15:0] world_vel_x,
   output logic signed [31:0] turn_rate
);
   localparam int F = ddo_pkg::TrigFracBits;
   localparam int Sh = 30 - F;

   logic [31:0] turn_gain_ff, rate_gain_ff;
   logic signed [47:0] x_acc_ff, y_acc_ff;
   logic [31:0] head_ff;
   logic signed [16:0] sum_ff;
   logic [16:0] mag_ff;
   logic neg_ff;
   logic [15:0] dt_ff;
   logic [1:0] quad_ff;
   logic signed [33:0] cx_ff, cy_ff, cz_ff;
   logic signed [F+1:0] cos_ff, sin_ff;
   logic signed [F+18:0] sc_ff, ss_ff;
   logic signed [F+35:0] dx_ff, dy_ff;
   logic [32:0] mt_ff;
   logic [64:0] dg_ff;
   logic [48:0] rg_ff;
   logic signed [15:0] vx_ff;
   logic signed [31:0] rate_ff;

   logic [31:0] q_sum;
   logic [1:0] q;
   logic [31:0] ru;
   logic signed [33:0] sx, sy, cx_n, cy_n, cz_n;
   logic signed [33:0] atan_ext;
   logic signed [34:0] rc, rs;
   logic signed [F+1:0] c_t, s_t, c_q, s_q;
   logic signed [F+18:0] vx_full;
   logic [48:0] rate_r;
   logic [64:0] dg_r;
   logic [31:0] delta;
   logic [31:0] rate_sat;

   function automatic logic signed [F+1:0] clamp(input logic signed [34:0] v);
      logic signed [34:0] one;
      one = 35'sd1 <<< F;
      if (v > one) return one[F+1:0];
      if (v < -one) return (F+2)'(-one);
      return v[F+1:0];
   endfunction

   assign dg_r = dg_ff + 65'(1 << 16);

   always_comb begin
      q_sum = head_ff + 32'h2000_0000;
      q = q_sum[31:30];
      ru = head_ff - {q, 30'd0};
      sx = cx_ff >>> cmd.step;
      sy = cy_ff >>> cmd.step;
      atan_ext = {2'b00, ddo_pkg::atan_lut(cmd.step)};
      if (cz_ff < 0) begin
         cx_n = cx_ff + sy; cy_n = cy_ff - sx; cz_n = cz_ff + atan_ext;
      end else begin
         cx_n = cx_ff - sy; cy_n = cy_ff + sx; cz_n = cz_ff - atan_ext;
      end
      rc = ($signed({cx_ff[33], cx_ff}) + (35'sd1 <<< (Sh - 1))) >>> Sh;
      rs = ($signed({cy_ff[33], cy_ff}) + (35'sd1 <<< (Sh - 1))) >>> Sh;
      c_t = clamp(rc);
      s_t = clamp(rs);
      case (quad_ff)
         2'd0: begin c_q = c_t; s_q = s_t; end
         2'd1: begin c_q = -s_t; s_q = c_t; end
         2'd2: begin c_q = -c_t; s_q = -s_t; end
         default: begin c_q = s_t; s_q = -c_t; end
      endcase
      vx_full = (sc_ff + (F+19)'(1 <<< F)) >>> (F + 1);
      rate_r = rg_ff + 49'(1 << 15);
      if (neg_ff) begin
         delta = 32'd0 - dg_r[48:17];
         rate_sat = (rate_r[48:16] > 33'h8000_0000) ? 32'h8000_0000
                    : 32'd0 - rate_r[47:16];
      end else begin
         delta = dg_r[48:17];
         rate_sat = (rate_r[48:16] > 33'h7FFF_FFFF) ? 32'h7FFF_FFFF : rate_r[47:16];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         turn_gain_ff <= ddo_pkg::TurnGainReset;
         rate_gain_ff <= ddo_pkg::RateGainReset;
         x_acc_ff <= '0;
         y_acc_ff <= '0;
         head_ff <= '0;
      end else begin
         if (csr_we) begin
            if (csr_index == ddo_pkg::CSR_TURN_GAIN) turn_gain_ff <= csr_data;
            else rate_gain_ff <= csr_data;
         end
         if (cmd.op == ddo_pkg::OP_UPDATE) begin
            x_acc_ff <= x_acc_ff + 48'(dx_ff >>> (F + 1));
            y_acc_ff <= y_acc_ff + 48'(dy_ff >>> (F + 1));
            head_ff <= head_ff + delta;
         end
      end
   end

   always_ff @(posedge clock) begin
      case (cmd.op)
         ddo_pkg::OP_LOAD: begin
            sum_ff <= 17'(left_speed) + 17'(right_speed);
            mag_ff <= (right_speed >= left_speed)
                      ? 17'(17'(right_speed) - 17'(left_speed))
                      : 17'(17'(left_speed) - 17'(right_speed));
            neg_ff <= right_speed < left_speed;
            dt_ff <= elapsed_time;
            quad_ff <= q;
            cx_ff <= 34'(ddo_pkg::CordicGainQ30);
            cy_ff <= '0;
            cz_ff <= 34'(signed'(ru));
         end
         ddo_pkg::OP_CORDIC: begin
            cx_ff <= cx_n; cy_ff <= cy_n; cz_ff <= cz_n;
         end
         ddo_pkg::OP_TRIG: begin
            cos_ff <= c_q; sin_ff <= s_q;
         end
         ddo_pkg::OP_MUL_SC: sc_ff <= (F+19)'(sum_ff * cos_ff);
         ddo_pkg::OP_MUL_SS: begin
            ss_ff <= (F+19)'(sum_ff * sin_ff);
            vx_ff <= vx_full[15:0];
         end
         ddo_pkg::OP_MUL_XT: dx_ff <= (F+36)'(sc_ff * $signed({1'b0, dt_ff}))
                                      + (F+36)'(1 <<< F);
         ddo_pkg::OP_MUL_YT: dy_ff <= (F+36)'(ss_ff * $signed({1'b0, dt_ff}))
                                      + (F+36)'(1 <<< F);
         ddo_pkg::OP_MUL_MT: mt_ff <= 33'(mag_ff * dt_ff);
         ddo_pkg::OP_MUL_DG: dg_ff <= 65'(mt_ff * turn_gain_ff);
         ddo_pkg::OP_MUL_RG: rg_ff <= 49'(mag_ff * rate_gain_ff);
         ddo_pkg::OP_UPDATE: rate_ff <= rate_sat;
         default: ;
      endcase
   end

   assign pos_x = x_acc_ff;
   assign pos_y = y_acc_ff;
   assign heading = head_ff;
   assign world_vel_x = vx_ff;
   assign turn_rate = rate_ff;
endmodule

FILE: rtl/core/diff_drive_odometry.sv
// Differential-drive odometry. Each request word (wheel speeds, elapsed time)
// updates the pose and returns one response word with the new pose, the
// world x velocity and the turn rate. The response becomes valid after 30
// iterations of the shared CORDIC for the old heading, one rounding step,
// seven product steps (one per cycle) and one update step. A new request
// is taken the cycle after the response is accepted, so response stalls delay
// the next request. One item is in flight at a time; the user must write
// gains only while the block is idle, and the block does not enforce it.
`include "diff_drive_odometry_defines.svh"
module diff_drive_odometry (
   input logic clock,
   input logic reset,
   ddo_req_if.sink req,
   ddo_rsp_if.source rsp,
   ddo_csr_if.sink csr
);
   logic busy, req_fire, rsp_fire, csr_we;
   ddo_pkg::cmd_type cmd;

   assign req.ready = !busy;
   assign req_fire = req.valid && req.ready;
   assign rsp_fire = rsp.valid && rsp.ready;
   assign csr.ready = 1'b1;
   assign csr_we = csr.valid && csr.ready;

   ddo_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_fire(req_fire), .rsp_fire(rsp_fire),
      .busy(busy), .rsp_valid(rsp.valid), .cmd(cmd)
   );

   ddo_dp u_dp (
      .clock(clock), .reset(reset), .cmd(cmd),
      .left_speed(req.left_speed), .right_speed(req.right_speed),
      .elapsed_time(req.elapsed_time),
      .csr_we(csr_we), .csr_index(csr.index), .csr_data(csr.data),
      .pos_x(rsp.pos_x), .pos_y(rsp.pos_y), .heading(rsp.heading),
      .world_vel_x(rsp.world_vel_x), .turn_rate(rsp.turn_rate)
   );

   `DDO_ASSERT_IMPL(a_no_accept_busy, clock, reset, rsp.valid, !req.ready)
   `DDO_ASSERT_NEXT(a_rsp_done, clock, reset, rsp_fire, req.ready)
   `DDO_ASSERT_NEXT(a_accept_not_valid, clock, reset, req_fire, !rsp.valid)
endmodule
